[rtl/gbpw_pkg.sv]
// Shared types and constants for the glyph bitmap pixel writer.
// Depends on nothing; every other file takes names from here by scope.
package gbpw_pkg;

  localparam int BYTE_W      = 8;
  localparam int LANES       = 8;
  localparam int LANE_IDX_W  = $clog2(LANES);
  localparam int OFF_W       = 19;
  localparam int COLOR_W     = 32;
  localparam int COORD_W     = 11;
  localparam int POS_W       = 12;
  localparam int BPR_W       = 6;
  localparam int ROW_W       = 10;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;

  localparam logic [ROW_W-1:0] ROW_MAX = 10'd1023;

  // Register map of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X      = 4'd0,
    REG_ORIGIN_Y      = 4'd1,
    REG_BYTES_PER_ROW = 4'd2,
    REG_INK_COLOR     = 4'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [BPR_W-1:0]   bytes_per_row;
    logic [COLOR_W-1:0] ink_color;
  } cfg_t;

  // One lane's finding for one bitmap bit
  typedef struct packed {
    logic             visible;
    logic [OFF_W-1:0] offset;
  } lane_t;

endpackage

[rtl/gbpw_if.sv]
// Channel interfaces: bitmap byte input, pixel write output, register write.
// Depends on gbpw_pkg for field widths.
interface gbpw_in_if;
  logic                       valid;
  logic                       ready;
  logic [gbpw_pkg::BYTE_W-1:0] glyph_byte;
  logic                       last_byte;
  modport source (output valid, output glyph_byte, output last_byte, input ready);
  modport sink   (input valid, input glyph_byte, input last_byte, output ready);
endinterface

interface gbpw_out_if;
  logic                         valid;
  logic                         ready;
  logic [gbpw_pkg::OFF_W-1:0]   pixel_offset;
  logic [gbpw_pkg::COLOR_W-1:0] pixel_color;
  logic                         last_write;
  modport source (output valid, output pixel_offset, output pixel_color,
                  output last_write, input ready);
  modport sink   (input valid, input pixel_offset, input pixel_color,
                  input last_write, output ready);
endinterface

interface gbpw_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gbpw_pkg::CFG_IDX_W-1:0]  index;
  logic [gbpw_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/gbpw_cfg_regs.sv]
// Configuration register file: origin, bytes per row, ink color.
// Depends on gbpw_pkg and the gbpw_cfg_if interface.
module gbpw_cfg_regs (
  input  logic            clk_i,
  input  logic            rst_ni,
  gbpw_cfg_if.sink        cfg_i,
  output gbpw_pkg::cfg_t  cfg_o
);

  gbpw_pkg::cfg_t cfg_q, cfg_d;

  // Always take a write beat
  assign cfg_i.ready = 1'b1;

  // Decode the register index; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        gbpw_pkg::REG_ORIGIN_X:      cfg_d.origin_x      = cfg_i.data[gbpw_pkg::COORD_W-1:0];
        gbpw_pkg::REG_ORIGIN_Y:      cfg_d.origin_y      = cfg_i.data[gbpw_pkg::COORD_W-1:0];
        gbpw_pkg::REG_BYTES_PER_ROW: cfg_d.bytes_per_row = cfg_i.data[gbpw_pkg::BPR_W-1:0];
        gbpw_pkg::REG_INK_COLOR:     cfg_d.ink_color     = cfg_i.data[gbpw_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x      <= '0;
      cfg_q.origin_y      <= '0;
      cfg_q.bytes_per_row <= 6'd1;
      cfg_q.ink_color     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/gbpw_lane.sv]
// One pixel lane: screen column, clipping test and linear offset for one bit.
// Depends on gbpw_pkg.
module gbpw_lane #(
  parameter int SCREEN_WIDTH  = 800,
  parameter int SCREEN_HEIGHT = 480,
  parameter int LANE          = 0,
  parameter int BASE_W        = 24
) (
  input  logic                              pixel_bit_i,
  input  logic signed [gbpw_pkg::POS_W-1:0] y_i,
  input  logic signed [gbpw_pkg::POS_W-1:0] xbase_i,
  input  logic [BASE_W-1:0]                 row_base_i,
  output gbpw_pkg::lane_t                   lane_o
);

  localparam int CMP_W = gbpw_pkg::POS_W + 2;

  logic signed [gbpw_pkg::POS_W-1:0] x;
  logic [CMP_W-1:0]                  x_u, y_u;
  logic [BASE_W-1:0]                 sum;

  // Column of this lane, leftmost lane first
  assign x = xbase_i + $signed(gbpw_pkg::POS_W'(LANE));

  assign x_u = CMP_W'(x[gbpw_pkg::POS_W-2:0]);
  assign y_u = CMP_W'(y_i[gbpw_pkg::POS_W-2:0]);

  // Drop pixels left, above, right of or below the screen
  assign lane_o.visible = pixel_bit_i
                        && !x[gbpw_pkg::POS_W-1] && !y_i[gbpw_pkg::POS_W-1]
                        && (x_u < CMP_W'(SCREEN_WIDTH))
                        && (y_u < CMP_W'(SCREEN_HEIGHT));

  assign sum = row_base_i + BASE_W'(x[gbpw_pkg::POS_W-2:0]);
  assign lane_o.offset = sum[gbpw_pkg::OFF_W-1:0];

endmodule

[rtl/gbpw_merge.sv]
// Merge stage: holds the lane results of one byte and emits the visible
// pixels left to right through an output register, one beat per cycle
// while out_o is ready. Depends on gbpw_pkg and gbpw_out_if.
module gbpw_merge (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  gbpw_pkg::lane_t              lanes_i [gbpw_pkg::LANES],
  input  logic [gbpw_pkg::COLOR_W-1:0] color_i,
  output logic                         free_o,
  gbpw_out_if.source                   out_o
);

  logic [gbpw_pkg::LANES-1:0]      mask_q, mask_d, rest;
  logic [gbpw_pkg::OFF_W-1:0]      off_q [gbpw_pkg::LANES];
  logic [gbpw_pkg::LANE_IDX_W-1:0] sel;
  logic                            found;
  logic                            emit;
  logic                            out_v_q, out_v_d;
  logic [gbpw_pkg::OFF_W-1:0]      out_off_q;
  logic [gbpw_pkg::COLOR_W-1:0]    out_color_q;
  logic                            out_last_q;

  // Pick the leftmost pending pixel
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int k = 0; k < gbpw_pkg::LANES; k++) begin
      if (!found && mask_q[k]) begin
        sel   = gbpw_pkg::LANE_IDX_W'(k);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    rest      = mask_q;
    rest[sel] = 1'b0;
  end

  // Emit when something is pending and the output register can take it
  assign emit   = found && (!out_v_q || out_o.ready);
  assign free_o = !found || (emit && (rest == '0));

  always_comb begin
    mask_d = mask_q;
    if (load_i) begin
      for (int k = 0; k < gbpw_pkg::LANES; k++) begin
        mask_d[k] = lanes_i[k].visible;
      end
    end else if (emit) begin
      mask_d = rest;
    end
  end

  assign out_v_d = emit ? 1'b1 : (out_o.ready ? 1'b0 : out_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      mask_q  <= mask_d;
      out_v_q <= out_v_d;
    end
  end

  // Capture lane offsets and the output beat payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int k = 0; k < gbpw_pkg::LANES; k++) begin
        off_q[k] <= lanes_i[k].offset;
      end
    end
    if (emit) begin
      out_off_q   <= off_q[sel];
      out_color_q <= color_i;
      out_last_q  <= (rest == '0);
    end
  end

  assign out_o.valid        = out_v_q;
  assign out_o.pixel_offset = out_off_q;
  assign out_o.pixel_color  = out_color_q;
  assign out_o.last_write   = out_last_q;

endmodule

[rtl/glyph_bitmap_pixel_writer.sv]
// Top level of the glyph bitmap pixel writer: position tracking, eight
// pixel lanes and the merge stage. Depends on gbpw_pkg, gbpw_if,
// gbpw_cfg_regs, gbpw_lane and gbpw_merge.
//
//   port    dir  beat carries
//   in_i    in   glyph_byte, last_byte (one bitmap byte)
//   out_o   out  pixel_offset, pixel_color, last_write (one framebuffer write)
//   cfg_i   in   index, data (one register write)
//
// The merge stage drives one pixel write per cycle onto out_o while out_o is
// ready, one for each visible set bit of a byte (at most 8).
// A byte passes the stage register, the merge mask and the output register.
// Reset clears position, pipeline valids, origin and ink; bytes per row is 1.
// A stalled out_o holds its beat; in_i keeps taking bytes until the
// stage register in front of the merge stage is full.
module glyph_bitmap_pixel_writer #(
  parameter int SCREEN_WIDTH      = 800,
  parameter int SCREEN_HEIGHT     = 480,
  parameter int MAX_BYTES_PER_ROW = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gbpw_in_if.sink    in_i,
  gbpw_out_if.source out_o,
  gbpw_cfg_if.sink   cfg_i
);

  localparam int COL_W   = (MAX_BYTES_PER_ROW > 1) ? $clog2(MAX_BYTES_PER_ROW) : 1;
  localparam int WW      = $clog2(SCREEN_WIDTH + 1);
  localparam int BASE_W0 = gbpw_pkg::POS_W + WW;
  localparam int BASE_W  = (BASE_W0 > gbpw_pkg::OFF_W) ? BASE_W0 : gbpw_pkg::OFF_W;
  localparam int BPR_EW  = gbpw_pkg::BPR_W + 1;
  localparam logic [BPR_EW-1:0] MAX_BPR = BPR_EW'(MAX_BYTES_PER_ROW);

  gbpw_pkg::cfg_t cfg;

  logic [COL_W-1:0]          col_q, col_d;
  logic [gbpw_pkg::ROW_W-1:0] row_q, row_d;
  logic [BPR_EW-1:0]         bpr_eff;
  logic [7:0]                col_next;
  logic                      accept;

  logic                              s1_v_q, s1_v_d;
  logic [gbpw_pkg::BYTE_W-1:0]       s1_byte_q;
  logic signed [gbpw_pkg::POS_W-1:0] s1_y_q, s1_xbase_q, y_d, xbase_d;
  logic [BASE_W-1:0]                 row_base;
  logic                              merge_free;
  logic                              load;

  gbpw_pkg::lane_t lanes [gbpw_pkg::LANES];

  gbpw_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Clamp bytes per row to the range 1..MAX_BYTES_PER_ROW
  always_comb begin
    if (cfg.bytes_per_row == '0) begin
      bpr_eff = BPR_EW'(1);
    end else if ({1'b0, cfg.bytes_per_row} > MAX_BPR) begin
      bpr_eff = MAX_BPR;
    end else begin
      bpr_eff = {1'b0, cfg.bytes_per_row};
    end
  end

  assign in_i.ready = !s1_v_q || merge_free;
  assign accept     = in_i.valid && in_i.ready;
  assign load       = s1_v_q && merge_free;

  // Screen row and left column of this byte
  assign y_d     = $signed({cfg.origin_y[gbpw_pkg::COORD_W-1], cfg.origin_y})
                 + $signed({2'b00, row_q});
  assign xbase_d = $signed({cfg.origin_x[gbpw_pkg::COORD_W-1], cfg.origin_x})
                 + $signed(gbpw_pkg::POS_W'({col_q, 3'b000}));

  // Step the position: wrap to the next row, saturate it, reset on last byte
  assign col_next = 8'(col_q) + 8'd1;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (in_i.last_byte) begin
        col_d = '0;
        row_d = '0;
      end else if (col_next >= 8'(bpr_eff)) begin
        col_d = '0;
        if (row_q < gbpw_pkg::ROW_MAX) begin
          row_d = row_q + 1'b1;
        end
      end else begin
        col_d = col_next[COL_W-1:0];
      end
    end
  end

  assign s1_v_d = accept ? 1'b1 : (merge_free ? 1'b0 : s1_v_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      s1_v_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      s1_v_q <= s1_v_d;
    end
  end

  // Hold the accepted byte and its coordinates for the lanes
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_byte_q  <= in_i.glyph_byte;
      s1_y_q     <= y_d;
      s1_xbase_q <= xbase_d;
    end
  end

  // Start of the screen row, shared by all lanes
  assign row_base = BASE_W'(s1_y_q[gbpw_pkg::POS_W-2:0]) * BASE_W'(SCREEN_WIDTH);

  for (genvar k = 0; k < gbpw_pkg::LANES; k++) begin : g_lane
    gbpw_lane #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .LANE          (k),
      .BASE_W        (BASE_W)
    ) u_lane (
      .pixel_bit_i (s1_byte_q[gbpw_pkg::BYTE_W-1-k]),
      .y_i         (s1_y_q),
      .xbase_i     (s1_xbase_q),
      .row_base_i  (row_base),
      .lane_o      (lanes[k])
    );
  end

  gbpw_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .lanes_i (lanes),
    .color_i (cfg.ink_color),
    .free_o  (merge_free),
    .out_o   (out_o)
  );

endmodule

[rtl/gbpw_checker.sv]
// Port-level checks for the glyph bitmap pixel writer, attached by bind.
// Depends on gbpw_pkg and the top level's ports.
module gbpw_checker #(
  parameter int SCREEN_WIDTH  = 800,
  parameter int SCREEN_HEIGHT = 480
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [gbpw_pkg::OFF_W-1:0] out_offset_i,
  input logic                       out_last_i
);

  localparam longint AREA     = longint'(SCREEN_WIDTH) * longint'(SCREEN_HEIGHT);
  localparam bit     AREA_BIG = AREA > (64'd1 << gbpw_pkg::OFF_W);

  // Hold a stalled write beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("pixel write dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_offset_i) && $stable(out_last_i))
    else $error("stalled pixel write changed");

  // Writes of one byte follow each other without a gap
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=> out_valid_i)
    else $error("gap inside the writes of one byte");

  // Offsets stay inside the framebuffer
  a_in_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> AREA_BIG || (longint'(out_offset_i) < AREA))
    else $error("pixel offset outside the framebuffer");

  // Writes of one byte go left to right
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |=>
      AREA_BIG || (out_offset_i > $past(out_offset_i)))
    else $error("pixel writes of one byte out of order");

endmodule

bind glyph_bitmap_pixel_writer gbpw_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_gbpw_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_offset_i (out_o.pixel_offset),
  .out_last_i   (out_o.last_write)
);

[bench/tb_glyph_bitmap_pixel_writer.sv]
// Self-checking bench for glyph_bitmap_pixel_writer: a directed table, then random glyphs.
// Drives beats on the gbpw_if channels; checks writes against typed rows or a blit model.
// Depends on gbpw_pkg, gbpw_if and the RTL top.
module tb_glyph_bitmap_pixel_writer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCREEN_W      = 800;
  localparam int SCREEN_H      = 480;
  localparam int MAX_BPR       = 32;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT   = 2000;
  localparam int RAND_PHASES   = 10;
  localparam int PHASE_BYTES   = 29;
  localparam int SPARE_LO      = int'(gbpw_pkg::REG_INK_COLOR) + 1;

  localparam logic [gbpw_pkg::CFG_IDX_W-1:0] REG_SPARE_TOP = '1;
  localparam logic [gbpw_pkg::COLOR_W-1:0]   INK_WHITE     = '1;
  localparam logic [gbpw_pkg::COLOR_W-1:0]   INK_MIX       = 32'hA5C3_5A3C;

  typedef enum logic {DO_WRITE_REG, DO_SEND_BYTE} row_kind_e;

  // One line of the directed table; typed rows carry their writes inline
  typedef struct packed {
    row_kind_e                        kind;
    logic [gbpw_pkg::CFG_IDX_W-1:0]   reg_idx;
    logic [gbpw_pkg::CFG_DATA_W-1:0]  reg_val;
    logic [gbpw_pkg::BYTE_W-1:0]      bits;
    logic                             last;
    logic                             typed;
    logic [3:0]                       n_px;
    logic [gbpw_pkg::OFF_W-1:0]       first_off;
    logic [gbpw_pkg::COLOR_W-1:0]     color;
  } stim_row_t;

  typedef struct packed {
    logic [gbpw_pkg::OFF_W-1:0]   offset;
    logic [gbpw_pkg::COLOR_W-1:0] color;
    logic                         last;
  } pix_t;

  localparam int N_DIRECTED = 39;
  localparam stim_row_t DIRECTED [0:N_DIRECTED-1] = '{
    // reset state: origin at the corner, one byte per row, black ink
    '{DO_SEND_BYTE, '0, '0, 8'h80, 1'b0, 1'b1, 4'd1, 19'd0, 32'd0},
    '{DO_SEND_BYTE, '0, '0, 8'hFF, 1'b1, 1'b1, 4'd8, 19'd800, 32'd0},
    '{DO_SEND_BYTE, '0, '0, 8'h00, 1'b1, 1'b1, 4'd0, '0, '0},
    // right edge, exact fit and one pixel over
    '{DO_WRITE_REG, gbpw_pkg::REG_INK_COLOR, INK_WHITE, '0, 1'b0, 1'b0, '0, '0, '0},
    '{DO_WRITE_REG, gbpw_pkg::REG_ORIGIN_X, 32'd792, '0, 1'b0, 1'b0, '0, '0, '0},
    '{DO_SEND_BYTE, '0, '0, 8'hFF, 1'b1, 1'b1, 4'd8, 19'd792, INK_WHITE},
    '{DO_WRITE_REG, gbpw_pkg::REG_ORIGIN_X, 32'd793, '0, 1'b0, 1'b0, '0, '0, '0},
    '{DO_SEND_BYTE, '0, '0, 8'hFF, 1'b1, 1'b1, 4'd7, 19'd793, INK_WHITE},
    // left edge: most negative origin, then a partly visible byte
    '{DO_WRITE_REG, gbpw_pkg::REG_ORIGIN_X, 32'hFFFF_FC00, '0, 1'b0, 1'b0, '0, '0, '0},
    '{DO_SEND_BYTE, '0, '0, 8'hFF, 1'b1, 1'b1, 4'd0, '0, '0},
    '{DO_WRITE_REG, gbpw_pkg::REG_ORIGIN_X, 32'h0000_07FD, '0, 1'b0, 1'b0, '0, '0, '0},
    '{DO_SEND_BYTE, '0, '0, 8'hFF, 1'b1, 1'b1, 4'd5, 19'd0, INK_WHITE},
    // bottom edge and the largest row origin
    '{DO_WRITE_REG, gbpw_pkg::REG_ORIGIN_X, 32'd0, '0, 1'b0, 1'b0, '0, '0, '0},
    '{DO_WRITE_REG, gbpw_pkg::REG_ORIGIN_Y, 32'd479, '0, 1'b0, 1'b0, '0, '0, '0},
    '{DO_SEND_BYTE, '0, '0, 8'h01, 1'b0, 1'b1, 4'd1, 19'd383207, INK_WHITE},
    '{DO_SEND_BYTE, '0, '0, 8'hFF, 1'b1, 1'b1, 4'd0, '0, '0},
    '{DO_WRITE_REG, gbpw_pkg::REG_ORIGIN_Y, 32'd1023, '0, 1'b0, 1'b0, '0, '0, '0},
    '{DO_SEND_BYTE, '0, '0, 8'hFF, 1'b1, 1'b1, 4'd0, '0, '0},
    // top edge: row above the screen, next row lands on row zero
    '{DO_WRITE_REG, gbpw_pkg::REG_ORIGIN_Y, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0, '0, '0},
    '{DO_SEND_BYTE, '0, '0, 8'hFF, 1'b0, 1'b1, 4'd0, '0, '0},
    '{DO_SEND_BYTE, '0, '0, 8'h18, 1'b1, 1'b1, 4'd2, 19'd3, INK_WHITE},
    // zero bytes per row acts as one
    '{DO_WRITE_REG, gbpw_pkg::REG_ORIGIN_Y, 32'd0, '0, 1'b0, 1'b0, '0, '0, '0},
    '{DO_WRITE_REG, gbpw_pkg::REG_BYTES_PER_ROW, 32'd0, '0, 1'b0, 1'b0, '0, '0, '0},
    '{DO_SEND_BYTE, '0, '0, 8'h80, 1'b0, 1'b1, 4'd1, 19'd0, INK_WHITE},
    '{DO_SEND_BYTE, '0, '0, 8'h80, 1'b1, 1'b1, 4'd1, 19'd800, INK_WHITE},
    // oversized bytes per row clamps to the maximum
    '{DO_WRITE_REG, gbpw_pkg::REG_INK_COLOR, INK_MIX, '0, 1'b0, 1'b0, '0, '0, '0},
    '{DO_WRITE_REG, gbpw_pkg::REG_BYTES_PER_ROW, 32'd63, '0, 1'b0, 1'b0, '0, '0, '0},
    '{DO_SEND_BYTE, '0, '0, 8'h01, 1'b0, 1'b1, 4'd1, 19'd7, INK_MIX},
    '{DO_SEND_BYTE, '0, '0, 8'h01, 1'b1, 1'b1, 4'd1, 19'd15, INK_MIX},
    // shrink the row width under a column already reached
    '{DO_WRITE_REG, gbpw_pkg::REG_BYTES_PER_ROW, 32'd4, '0, 1'b0, 1'b0, '0, '0, '0},
    '{DO_SEND_BYTE, '0, '0, 8'h80, 1'b0, 1'b0, '0, '0, '0},
    '{DO_SEND_BYTE, '0, '0, 8'h80, 1'b0, 1'b0, '0, '0, '0},
    '{DO_SEND_BYTE, '0, '0, 8'h80, 1'b0, 1'b0, '0, '0, '0},
    '{DO_WRITE_REG, gbpw_pkg::REG_BYTES_PER_ROW, 32'd2, '0, 1'b0, 1'b0, '0, '0, '0},
    '{DO_SEND_BYTE, '0, '0, 8'h80, 1'b0, 1'b0, '0, '0, '0},
    '{DO_SEND_BYTE, '0, '0, 8'hC3, 1'b1, 1'b0, '0, '0, '0},
    // write to an unmapped index must change nothing
    '{DO_WRITE_REG, REG_SPARE_TOP, 32'h5555_AAAA, '0, 1'b0, 1'b0, '0, '0, '0},
    '{DO_SEND_BYTE, '0, '0, 8'hA5, 1'b1, 1'b0, '0, '0, '0},
    '{DO_WRITE_REG, gbpw_pkg::REG_BYTES_PER_ROW, 32'd1, '0, 1'b0, 1'b0, '0, '0, '0}
  };

  logic clk = 1'b0;
  logic rst_n;

  gbpw_in_if  in_bus ();
  gbpw_out_if out_bus ();
  gbpw_cfg_if cfg_bus ();

  glyph_bitmap_pixel_writer #(
    .SCREEN_WIDTH      (SCREEN_W),
    .SCREEN_HEIGHT     (SCREEN_H),
    .MAX_BYTES_PER_ROW (MAX_BPR)
  ) DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  // Blit model: registers and glyph position
  logic signed [gbpw_pkg::COORD_W-1:0] ox_reg;
  logic signed [gbpw_pkg::COORD_W-1:0] oy_reg;
  logic [gbpw_pkg::BPR_W-1:0]          bpr_reg;
  logic [gbpw_pkg::COLOR_W-1:0]        ink_reg;
  logic [4:0]                          col_pos;
  logic [gbpw_pkg::ROW_W-1:0]          row_pos;

  pix_t px_q[$];
  pix_t got_px;
  pix_t want_px;
  bit   src_idle;
  bit   sink_stalls;
  int   n_errors;
  int   n_checked;
  int   n_bytes;
  int   n_reg_writes;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Effective bitmap bytes per glyph row
  function automatic int row_bytes();
    if (bpr_reg == '0) return 1;
    if (int'(bpr_reg) > MAX_BPR) return MAX_BPR;
    return int'(bpr_reg);
  endfunction

  // Expand one bitmap byte into pixel writes and step the position
  function automatic void blit_byte(input logic [gbpw_pkg::BYTE_W-1:0] bits,
                                    input logic last, input bit keep);
    int   y;
    int   xbase;
    int   x;
    int   n;
    pix_t p;
    n = 0;
    y = int'($signed(oy_reg)) + int'(row_pos);
    xbase = int'($signed(ox_reg)) + gbpw_pkg::BYTE_W * int'(col_pos);
    for (int k = gbpw_pkg::BYTE_W - 1; k >= 0; k--) begin
      if (bits[k]) begin
        x = xbase + (gbpw_pkg::BYTE_W - 1 - k);
        if (x >= 0 && y >= 0 && x < SCREEN_W && y < SCREEN_H) begin
          p.offset = gbpw_pkg::OFF_W'(y * SCREEN_W + x);
          p.color  = ink_reg;
          p.last   = 1'b0;
          if (keep) px_q.push_back(p);
          n++;
        end
      end
    end
    if (keep && n > 0) px_q[px_q.size() - 1].last = 1'b1;
    if (last) begin
      col_pos = '0;
      row_pos = '0;
    end else if (int'(col_pos) + 1 >= row_bytes()) begin
      col_pos = '0;
      if (row_pos != gbpw_pkg::ROW_MAX) row_pos++;
    end else begin
      col_pos++;
    end
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int idle_span(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [gbpw_pkg::COORD_W-1:0] pick_coord(input int span);
    case ($urandom_range(0, 7))
      0: return {1'b1, {(gbpw_pkg::COORD_W-1){1'b0}}};
      1: return {1'b0, {(gbpw_pkg::COORD_W-1){1'b1}}};
      2: return '0;
      3: return gbpw_pkg::COORD_W'(0 - int'($urandom_range(1, 16)));
      4: return gbpw_pkg::COORD_W'(span - int'($urandom_range(1, 8)));
      default: return gbpw_pkg::COORD_W'($urandom_range(0, span - 1));
    endcase
  endfunction

  task automatic wait_drained();
    while (px_q.size() != 0) @(negedge clk);
  endtask

  // Send one bitmap byte, record what it should draw, then hold off
  task automatic send_byte(input stim_row_t row, input int gap);
    pix_t p;
    in_bus.valid      <= 1'b1;
    in_bus.glyph_byte <= row.bits;
    in_bus.last_byte  <= row.last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    if (row.typed) begin
      blit_byte(row.bits, row.last, 1'b0);
      for (int i = 0; i < int'(row.n_px); i++) begin
        p.offset = row.first_off + gbpw_pkg::OFF_W'(i);
        p.color  = row.color;
        p.last   = (i == int'(row.n_px) - 1);
        px_q.push_back(p);
      end
    end else begin
      blit_byte(row.bits, row.last, 1'b1);
    end
    n_bytes++;
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Register write once the pipeline has emptied
  task automatic write_reg(input logic [gbpw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gbpw_pkg::CFG_DATA_W-1:0] value);
    in_bus.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      gbpw_pkg::REG_ORIGIN_X:      ox_reg  = value[gbpw_pkg::COORD_W-1:0];
      gbpw_pkg::REG_ORIGIN_Y:      oy_reg  = value[gbpw_pkg::COORD_W-1:0];
      gbpw_pkg::REG_BYTES_PER_ROW: bpr_reg = value[gbpw_pkg::BPR_W-1:0];
      gbpw_pkg::REG_INK_COLOR:     ink_reg = value[gbpw_pkg::COLOR_W-1:0];
      default: ;
    endcase
    n_reg_writes++;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Pixel write sink with random back-pressure
  initial begin
    int stall_left;
    stall_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
        stall_left = idle_span(sink_stalls);
      end
    end
  end

  // Compare each accepted pixel write with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got_px.offset = out_bus.pixel_offset;
      got_px.color  = out_bus.pixel_color;
      got_px.last   = out_bus.last_write;
      if (px_q.size() == 0) begin
        $error("pixel write with none expected: offset %0d color %08h",
               got_px.offset, got_px.color);
        n_errors++;
      end else begin
        want_px = px_q.pop_front();
        n_checked++;
        if (got_px.offset !== want_px.offset) begin
          $error("pixel_offset: expected %0d, got %0d", want_px.offset, got_px.offset);
          n_errors++;
        end
        if (got_px.color !== want_px.color) begin
          $error("pixel_color: expected %08h, got %08h", want_px.color, got_px.color);
          n_errors++;
        end
        if (got_px.last !== want_px.last) begin
          $error("last_write: expected %0b, got %0b", want_px.last, got_px.last);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: end the run after too long without any beat
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_glyph_bitmap_pixel_writer: done, errors");
    $finish;
  end

  initial begin
    int                              glyph_len;
    int                              cut;
    int                              eff;
    int                              budget;
    int                              n_directed;
    stim_row_t                       beat_row;
    logic [gbpw_pkg::CFG_DATA_W-1:0] value;

    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.glyph_byte = '0;
    in_bus.last_byte  = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = '0;
    cfg_bus.data      = '0;
    ox_reg            = '0;
    oy_reg            = '0;
    bpr_reg           = gbpw_pkg::BPR_W'(1);
    ink_reg           = '0;
    col_pos           = '0;
    row_pos           = '0;
    n_errors          = 0;
    n_checked         = 0;
    n_bytes           = 0;
    n_reg_writes      = 0;
    src_idle          = 1'b1;
    sink_stalls       = 1'b1;
    beat_row          = '0;
    beat_row.kind     = DO_SEND_BYTE;

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table
    for (int i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].kind == DO_WRITE_REG)
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
      else
        send_byte(DIRECTED[i], idle_span(src_idle));
    end
    n_directed = n_bytes;

    // Random phases: new settings, then mostly well-formed glyphs
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      src_idle    = ($urandom_range(0, 2) != 0);
      sink_stalls = ($urandom_range(0, 2) != 0);
      value = $urandom;
      value[gbpw_pkg::COORD_W-1:0] = pick_coord(SCREEN_W);
      write_reg(gbpw_pkg::REG_ORIGIN_X, value);
      value = $urandom;
      value[gbpw_pkg::COORD_W-1:0] = pick_coord(SCREEN_H);
      write_reg(gbpw_pkg::REG_ORIGIN_Y, value);
      value = $urandom;
      case ($urandom_range(0, 9))
        0: value[gbpw_pkg::BPR_W-1:0] = '0;
        1: value[gbpw_pkg::BPR_W-1:0] = gbpw_pkg::BPR_W'(MAX_BPR);
        2: value[gbpw_pkg::BPR_W-1:0] = gbpw_pkg::BPR_W'($urandom_range(MAX_BPR + 1, 63));
        3: value[gbpw_pkg::BPR_W-1:0] = gbpw_pkg::BPR_W'($urandom_range(5, MAX_BPR - 1));
        default: value[gbpw_pkg::BPR_W-1:0] = gbpw_pkg::BPR_W'($urandom_range(1, 4));
      endcase
      write_reg(gbpw_pkg::REG_BYTES_PER_ROW, value);
      case ($urandom_range(0, 5))
        0: value = '0;
        1: value = '1;
        default: value = $urandom;
      endcase
      write_reg(gbpw_pkg::REG_INK_COLOR, value);
      if ($urandom_range(0, 2) == 0)
        write_reg(gbpw_pkg::CFG_IDX_W'($urandom_range(SPARE_LO, 2**gbpw_pkg::CFG_IDX_W - 1)),
                  $urandom);

      eff = row_bytes();
      budget = PHASE_BYTES;
      while (budget > 0) begin
        glyph_len = eff * ((eff > 8) ? $urandom_range(1, 2) : $urandom_range(1, 5));
        // Broken glyph: end marker early, or missing so the position carries over
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, glyph_len) : glyph_len - 1;
        for (int b = 0; b < glyph_len && b <= cut && budget > 0; b++) begin
          case ($urandom_range(0, 9))
            0: beat_row.bits = '0;
            1: beat_row.bits = '1;
            default: beat_row.bits = gbpw_pkg::BYTE_W'($urandom);
          endcase
          beat_row.last = (b == cut);
          if ($urandom_range(0, 24) == 0) begin
            in_bus.valid <= 1'b0;
            @(negedge clk);
            wait_drained();
          end
          send_byte(beat_row, idle_span(src_idle));
          budget--;
        end
      end
    end

    // Drain and let the pipeline go quiet
    in_bus.valid <= 1'b0;
    @(negedge clk);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("tb_glyph_bitmap_pixel_writer: %0d bitmap bytes (%0d directed), %0d reg writes",
             n_bytes, n_directed, n_reg_writes);
    $display("tb_glyph_bitmap_pixel_writer: %0d pixel writes checked, all four edges clipped",
             n_checked);
    if (n_errors == 0) begin
      $display("tb_glyph_bitmap_pixel_writer: done, clean");
    end else begin
      $display("tb_glyph_bitmap_pixel_writer: done, errors");
    end
    $finish;
  end

endmodule
